// ===== src/lifo_pkg.sv =====
// ----------------------------------------------------------------------------
// lifo_pkg
// shared types and constants for the lifo stack with prefix sum
// ----------------------------------------------------------------------------
`default_nettype none

package lifo_pkg;

   localparam int DATA_W      = 32;
   localparam int CNT_W       = 7;
   localparam int IDX_W       = 6;
   localparam int FILL_W      = 7;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;

   localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_MULTI = 2'd2,
      OP_SUM   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic pop_load;
      logic sum_issue;
      logic sum_load;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic to_pop;
      logic to_sum;
      logic sum_last;
   } stat_type;

endpackage

`default_nettype wire

// ===== src/lifo_ctrl.sv =====
// ----------------------------------------------------------------------------
// lifo_ctrl
// sequencer for multi-cycle operations and the two result holding stages
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire lifo_pkg::stat_type stat,
   output lifo_pkg::cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_POP     = 4'b0010,
      S_SUM     = 4'b0100,
      S_SUMLAST = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      pend_valid_ff, pend_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;
   logic      imm_done;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && (!pend_valid_ff || out_free);
   assign accept     = req_tvalid && req_tready;
   assign imm_done   = accept && !stat.to_pop && !stat.to_sum;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.accept    = accept;
      cmd.pop_load  = (state_ff == S_POP);
      cmd.sum_issue = (state_ff == S_SUM);
      cmd.sum_load  = (state_ff == S_SUMLAST);
      cmd.out_load  = pend_valid_ff && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && stat.to_pop) begin
               state_in = S_POP;
            end else if (accept && stat.to_sum) begin
               state_in = S_SUM;
            end
         end
         S_POP: begin
            state_in = S_IDLE;
         end
         S_SUM: begin
            if (stat.sum_last) begin
               state_in = S_SUMLAST;
            end
         end
         S_SUMLAST: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (imm_done || cmd.pop_load || cmd.sum_load) begin
         pend_valid_in = 1'b1;
      end else if (cmd.out_load) begin
         pend_valid_in = 1'b0;
      end else begin
         pend_valid_in = pend_valid_ff;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/lifo_dpath.sv =====
// ----------------------------------------------------------------------------
// lifo_dpath
// stack memory, fill pointer, prefix accumulator and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_dpath #(
   parameter int DEPTH = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lifo_pkg::cmd_type              cmd,
   output lifo_pkg::stat_type                  stat,
   input  wire logic [1:0]                     opcode,
   input  wire logic [lifo_pkg::DATA_W-1:0]    push_value,
   input  wire logic [lifo_pkg::CNT_W-1:0]     drop_count,
   input  wire logic [lifo_pkg::IDX_W-1:0]     sum_index,
   output logic      [lifo_pkg::DATA_W-1:0]    result_value,
   output logic      [1:0]                     status,
   output logic      [lifo_pkg::FILL_W-1:0]    fill_level
);

   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PTR_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (PTR_W > lifo_pkg::CNT_W) ? PTR_W : lifo_pkg::CNT_W;
   localparam int DATA_W = lifo_pkg::DATA_W;
   localparam int FILL_W = lifo_pkg::FILL_W;

   logic [DATA_W-1:0] mem [DEPTH];

   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [PTR_W-1:0]  ptr_dec;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] rdata_ff;
   logic [DATA_W-1:0] pend_res_ff, pend_res_in;
   logic [1:0]        pend_st_ff, pend_st_in;
   logic [FILL_W-1:0] pend_fill_ff, pend_fill_in;
   logic [DATA_W-1:0] out_res_ff;
   logic [1:0]        out_st_ff;
   logic [FILL_W-1:0] out_fill_ff;

   logic              full, empty, out_range;
   logic [CMP_W-1:0]  ptr_ext, cnt_ext, idx_ext;
   logic              wr_en, rd_en;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] imm_res;
   logic [1:0]        imm_st;
   logic              pend_load;

   assign ptr_dec   = ptr_ff - 1'b1;
   assign full      = (ptr_ff == PTR_W'(DEPTH));
   assign empty     = (ptr_ff == '0);
   assign ptr_ext   = CMP_W'(ptr_ff);
   assign cnt_ext   = CMP_W'(drop_count);
   assign idx_ext   = CMP_W'(sum_index);
   assign out_range = (idx_ext >= ptr_ext);

   always_comb begin
      stat.to_pop   = (lifo_pkg::op_type'(opcode) == lifo_pkg::OP_POP) && !empty;
      stat.to_sum   = (lifo_pkg::op_type'(opcode) == lifo_pkg::OP_SUM) && !out_range;
      stat.sum_last = (cnt_ff == idx_ff);
   end

   always_comb begin
      ptr_in  = ptr_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      wr_en   = 1'b0;
      rd_en   = 1'b0;
      rd_addr = cnt_ff;
      imm_res = '0;
      imm_st  = lifo_pkg::ST_OK;
      if (cmd.accept) begin
         unique case (lifo_pkg::op_type'(opcode))
            lifo_pkg::OP_PUSH: begin
               if (full) begin
                  imm_st = lifo_pkg::ST_FULL;
               end else begin
                  wr_en  = 1'b1;
                  ptr_in = ptr_ff + 1'b1;
               end
            end
            lifo_pkg::OP_POP: begin
               if (empty) begin
                  imm_res = lifo_pkg::EMPTY_WORD;
                  imm_st  = lifo_pkg::ST_EMPTY;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_dec[AW-1:0];
                  ptr_in  = ptr_dec;
               end
            end
            lifo_pkg::OP_MULTI: begin
               // clip at empty
               ptr_in = (cnt_ext > ptr_ext) ? '0 : PTR_W'(ptr_ext - cnt_ext);
            end
            lifo_pkg::OP_SUM: begin
               if (out_range) begin
                  imm_st = lifo_pkg::ST_RANGE;
               end else begin
                  cnt_in = '0;
                  acc_in = '0;
                  idx_in = AW'(sum_index);
               end
            end
            default: begin
               imm_st = lifo_pkg::ST_OK;
            end
         endcase
      end
      if (cmd.sum_issue) begin
         // read data is registered and arrives in the cycle after its address
         rd_en   = 1'b1;
         rd_addr = cnt_ff;
         cnt_in  = cnt_ff + 1'b1;
         acc_in  = (cnt_ff == '0) ? acc_ff : acc_ff + rdata_ff;
      end
   end

   always_comb begin
      pend_load    = 1'b1;
      pend_res_in  = pend_res_ff;
      pend_st_in   = pend_st_ff;
      pend_fill_in = pend_fill_ff;
      if (cmd.pop_load) begin
         pend_res_in  = rdata_ff;
         pend_st_in   = lifo_pkg::ST_OK;
         pend_fill_in = FILL_W'(ptr_ff);
      end else if (cmd.sum_load) begin
         pend_res_in  = acc_ff + rdata_ff;
         pend_st_in   = lifo_pkg::ST_OK;
         pend_fill_in = FILL_W'(ptr_ff);
      end else if (cmd.accept && !stat.to_pop && !stat.to_sum) begin
         pend_res_in  = imm_res;
         pend_st_in   = imm_st;
         pend_fill_in = FILL_W'(ptr_in);
      end else begin
         pend_load    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ptr_ff[AW-1:0]] <= push_value;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      if (pend_load) begin
         pend_res_ff  <= pend_res_in;
         pend_st_ff   <= pend_st_in;
         pend_fill_ff <= pend_fill_in;
      end
      if (cmd.out_load) begin
         out_res_ff  <= pend_res_ff;
         out_st_ff   <= pend_st_ff;
         out_fill_ff <= pend_fill_ff;
      end
   end

   assign result_value = out_res_ff;
   assign status       = out_st_ff;
   assign fill_level   = out_fill_ff;

endmodule

`default_nettype wire

// ===== src/lifo_stack_with_prefix_sum_core.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_prefix_sum_core
// fixed-depth lifo of signed 32-bit words with push, pop, multi-pop and
// prefix sum, one result transaction per request transaction
// ----------------------------------------------------------------------------
//
// channel  direction  tdata (low bit up)                     tuser
// req      in         push_value, drop_count, sum_index      opcode
// rsp      out        result_value, fill_level               status
//
// push, multi-pop, empty pop, full push and out-of-range sum finish at acceptance
// pop: waits in S_POP, set by the registered read port of the stack memory
// prefix sum: runs through S_SUM and S_SUMLAST, one memory read per entry summed
// a finished result sits in a holding stage and then in the output register,
// so requests keep flowing while rsp_tready is low until both are occupied
// synchronous active-high reset clears the fill pointer and handshake state;
// memory contents stay undefined and are only read below the fill pointer
//
`default_nettype none

module lifo_stack_with_prefix_sum_core #(
   parameter int DEPTH = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // push_value[31:0], drop_count[38:32], sum_index[44:39], zero fill
   input  wire logic [lifo_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // opcode[1:0]
   input  wire logic [1:0]                           req_tuser,
   // response channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // result_value[31:0], fill_level[38:32], zero fill
   output logic      [lifo_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // status[1:0]
   output logic      [1:0]                           rsp_tuser
);

   localparam int DATA_W = lifo_pkg::DATA_W;
   localparam int CNT_W  = lifo_pkg::CNT_W;
   localparam int IDX_W  = lifo_pkg::IDX_W;
   localparam int FILL_W = lifo_pkg::FILL_W;
   localparam int PAD_W  = lifo_pkg::RSP_TDATA_W - DATA_W - FILL_W;

   lifo_pkg::cmd_type  cmd;
   lifo_pkg::stat_type stat;

   logic [DATA_W-1:0] result_value;
   logic [1:0]        status;
   logic [FILL_W-1:0] fill_level;

   // sequencing and handshake
   lifo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // stack storage and arithmetic
   lifo_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .opcode       (req_tuser),
      .push_value   (req_tdata[DATA_W-1:0]),
      .drop_count   (req_tdata[DATA_W+CNT_W-1:DATA_W]),
      .sum_index    (req_tdata[DATA_W+CNT_W+IDX_W-1:DATA_W+CNT_W]),
      .result_value (result_value),
      .status       (status),
      .fill_level   (fill_level)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, fill_level, result_value};
   assign rsp_tuser = status;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lifo stack with push, pop, multi-pop and
// prefix sum; a local stack image predicts every response, random
// stalls on both channels, one drain pause and one stretch at full rate
// ----------------------------------------------------------------------------

module tb_top;

   localparam int STACK_DEPTH = 64;
   localparam int IDLE_PCT    = 26;     // chance in a hundred that a side idles
   localparam int TOTAL_REQS  = 1050;   // stimulus stops once this many are queued
   localparam int DRAIN_AT    = 500;    // sender waits for a full drain here
   localparam int STEADY_END  = 750;    // no idling between DRAIN_AT and this
   localparam int TAIL_CYCLES = 100;    // margin beyond the longest prefix sum

   // one request transaction as the driver sees it
   typedef struct {
      lifo_pkg::op_type op;
      logic [31:0]      word;
      logic [6:0]       count;
      logic [5:0]       index;
   } stack_req_type;

   // one response transaction, as predicted
   typedef struct {
      logic [31:0]          value;
      lifo_pkg::status_type status;
      logic [6:0]           fill;
   } stack_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [lifo_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]                       req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [lifo_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]                       rsp_tuser;

   // bench bookkeeping
   stack_req_type queued_requests[$];     // filled by the stimulus block
   stack_rsp_type awaited_responses[$];   // predicted at request acceptance
   int            requests_outstanding = 0;
   int            requests_planned     = 0;
   int            planned_fill         = 0;   // fill as the generator sees it
   int            mismatch_count       = 0;
   logic          req_taken            = 1'b0;
   logic          steady               = 1'b0;

   // stack image used for prediction
   logic [31:0] stack_words[STACK_DEPTH];
   int          stack_fill = 0;

   lifo_stack_with_prefix_sum_core #(
      .DEPTH(STACK_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // reset held from the start, released on a falling edge
   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
   end

   // applies one operation to the stack image and returns its response
   function automatic stack_rsp_type compute_stack_response(lifo_pkg::op_type op,
         logic [31:0] word, logic [6:0] count, logic [5:0] index);
      stack_rsp_type rsp;
      int            removed;
      rsp.value  = '0;
      rsp.status = lifo_pkg::ST_OK;
      case (op)
         lifo_pkg::OP_PUSH: begin
            // full push drops the word and leaves the fill alone
            if (stack_fill >= STACK_DEPTH) begin
               rsp.status = lifo_pkg::ST_FULL;
            end else begin
               stack_words[stack_fill] = word;
               stack_fill++;
            end
         end
         lifo_pkg::OP_POP: begin
            if (stack_fill == 0) begin
               rsp.value  = lifo_pkg::EMPTY_WORD;
               rsp.status = lifo_pkg::ST_EMPTY;
            end else begin
               stack_fill--;
               rsp.value = stack_words[stack_fill];
            end
         end
         lifo_pkg::OP_MULTI: begin
            // removal stops at empty, status stays ok
            removed    = (int'(count) > stack_fill) ? stack_fill : int'(count);
            stack_fill = stack_fill - removed;
         end
         default: begin
            // index at or past the fill is flagged, nothing read
            if (int'(index) >= stack_fill) begin
               rsp.status = lifo_pkg::ST_RANGE;
            end else begin
               for (int i = 0; i <= int'(index); i++) rsp.value += stack_words[i];
            end
         end
      endcase
      rsp.fill = stack_fill[6:0];
      return rsp;
   endfunction

   // queues one request and keeps the generator's view of the fill current
   task automatic queue_op(lifo_pkg::op_type op, logic [31:0] word, logic [6:0] count,
         logic [5:0] index);
      stack_req_type item;
      item.op    = op;
      item.word  = word;
      item.count = count;
      item.index = index;
      queued_requests.push_back(item);
      requests_outstanding++;
      requests_planned++;
      case (op)
         lifo_pkg::OP_PUSH:  if (planned_fill < STACK_DEPTH) planned_fill++;
         lifo_pkg::OP_POP:   if (planned_fill > 0) planned_fill--;
         lifo_pkg::OP_MULTI:
            planned_fill = (int'(count) > planned_fill) ? 0 : planned_fill - int'(count);
         default:  ;
      endcase
   endtask

   // push with a word that now and then is one of the extremes
   task automatic queue_push();
      logic [31:0] word;
      case ($urandom_range(0, 9))
         0:       word = 32'h8000_0000;
         1:       word = 32'h7fff_ffff;
         2:       word = 32'hffff_ffff;
         default: word = $urandom;
      endcase
      queue_op(lifo_pkg::OP_PUSH, word, 7'($urandom_range(0, 64)),
         6'($urandom_range(0, 63)));
   endtask

   // sender stays quiet until every response has been checked
   task automatic wait_for_drain();
      while (requests_outstanding != 0) @(negedge clock);
   endtask

   // request driver: inputs change on the falling edge only
   always @(negedge clock) begin : drive_requests
      stack_req_type item;
      if (!reset) begin
         // a held transaction stays put until accepted
         if (!req_tvalid || req_taken) begin
            if (queued_requests.size() > 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               item = queued_requests.pop_front();
               req_tvalid <= 1'b1;
               // tdata: push_value, drop_count, sum_index, zero fill
               req_tdata  <= {3'b000, item.index, item.count, item.word};
               req_tuser  <= item.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // monitor: predicts on request acceptance, checks on response acceptance
   always @(posedge clock) begin : watch_channels
      stack_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            awaited_responses.push_back(compute_stack_response(
               lifo_pkg::op_type'(req_tuser),
               req_tdata[31:0], req_tdata[38:32], req_tdata[44:39]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_responses.size() == 0) begin
               $error("response with nothing awaited: value %h status %0d fill %0d",
                  rsp_tdata[31:0], rsp_tuser, rsp_tdata[38:32]);
               mismatch_count++;
            end else begin
               want = awaited_responses.pop_front();
               requests_outstanding--;
               if (rsp_tdata[31:0] !== want.value) begin
                  $error("result_value: expected %h, got %h", want.value, rsp_tdata[31:0]);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata[38:32] !== want.fill) begin
                  $error("fill_level: expected %0d, got %0d", want.fill, rsp_tdata[38:32]);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // stimulus: directed corners, then random sequences
   initial begin : stimulus
      int pick;
      int burst;
      logic [5:0] index;

      // empty stack: pop, multi-pop with zero and with full count, sum
      queue_op(lifo_pkg::OP_POP,   32'h0, 7'd0,  6'd0);
      queue_op(lifo_pkg::OP_MULTI, 32'h0, 7'd0,  6'd0);
      queue_op(lifo_pkg::OP_MULTI, 32'h0, 7'd64, 6'd0);
      queue_op(lifo_pkg::OP_SUM,   32'h0, 7'd0,  6'd0);
      // extremes of the word, then sums that wrap
      queue_op(lifo_pkg::OP_PUSH,  32'h7fff_ffff, 7'd0, 6'd0);
      queue_op(lifo_pkg::OP_PUSH,  32'h8000_0000, 7'd0, 6'd0);
      queue_op(lifo_pkg::OP_PUSH,  32'hffff_ffff, 7'd0, 6'd0);
      queue_op(lifo_pkg::OP_PUSH,  32'h0000_0000, 7'd0, 6'd0);
      queue_op(lifo_pkg::OP_SUM,   32'h0, 7'd0,  6'd0);
      queue_op(lifo_pkg::OP_SUM,   32'h0, 7'd0,  6'd1);
      queue_op(lifo_pkg::OP_SUM,   32'h0, 7'd0,  6'd3);
      // index equal to the fill and at the top of its range
      queue_op(lifo_pkg::OP_SUM,   32'h0, 7'd0,  6'd4);
      queue_op(lifo_pkg::OP_SUM,   32'h0, 7'd0,  6'd63);
      queue_op(lifo_pkg::OP_POP,   32'h0, 7'd0,  6'd0);
      queue_op(lifo_pkg::OP_MULTI, 32'h0, 7'd1,  6'd0);
      queue_op(lifo_pkg::OP_MULTI, 32'h0, 7'd0,  6'd0);
      queue_op(lifo_pkg::OP_PUSH,  32'h1234_5678, 7'd127, 6'd63);
      queue_op(lifo_pkg::OP_PUSH,  32'ha5a5_a5a5, 7'd0, 6'd0);
      queue_op(lifo_pkg::OP_POP,   32'hffff_ffff, 7'd64, 6'd63);
      // multi-pop that runs past empty
      queue_op(lifo_pkg::OP_MULTI, 32'h0, 7'd64, 6'd0);
      queue_op(lifo_pkg::OP_POP,   32'h0, 7'd0,  6'd0);

      // fill to the top, push while full, sum over the whole stack
      while (planned_fill < STACK_DEPTH) queue_push();
      queue_push();
      queue_op(lifo_pkg::OP_SUM, $urandom, 7'($urandom_range(0, 64)), 6'd63);

      while (requests_planned < TOTAL_REQS) begin
         // one pause for a full drain, then a stretch without idling
         if (requests_planned >= DRAIN_AT && requests_planned < STEADY_END && !steady) begin
            wait_for_drain();
            steady = 1'b1;
         end
         // the stretch lasts until its transactions have all been checked
         if (requests_planned >= STEADY_END && steady) begin
            wait_for_drain();
            steady = 1'b0;
         end

         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            // run into full and a little beyond
            burst = STACK_DEPTH - planned_fill + $urandom_range(1, 3);
            repeat (burst) queue_push();
         end else if (pick < 35) begin
            repeat ($urandom_range(1, 10)) queue_push();
         end else if (pick < 50) begin
            repeat ($urandom_range(1, 6))
               queue_op(lifo_pkg::OP_POP, $urandom, 7'($urandom_range(0, 64)),
                  6'($urandom_range(0, 63)));
         end else if (pick < 60) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 6);
            queue_op(lifo_pkg::OP_MULTI, $urandom, 7'(burst), 6'($urandom_range(0, 63)));
         end else if (pick < 88) begin
            // mostly in-range sums, some past the fill
            if (planned_fill > 0 && $urandom_range(0, 5) != 0)
               index = 6'($urandom_range(0, planned_fill - 1));
            else
               index = 6'($urandom_range(0, 63));
            queue_op(lifo_pkg::OP_SUM, $urandom, 7'($urandom_range(0, 64)), index);
         end else begin
            // noise: any operation with any field values
            queue_op(lifo_pkg::op_type'($urandom_range(0, 3)), $urandom,
               7'($urandom_range(0, 64)), 6'($urandom_range(0, 63)));
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && awaited_responses.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
src/lifo_pkg.sv
src/lifo_ctrl.sv
src/lifo_dpath.sv
src/lifo_stack_with_prefix_sum_core.sv
tb/sv/tb_top.sv
